### rtl/core/rpc_pkg.sv
// Shared types and constants for the RC PWM pulse capture block.
// Used by every module in rtl/core; depends on nothing.
package rpc_pkg;

  localparam int RpcChannels   = 5;   // default channel count
  localparam int PinW          = 5;   // pins carried by one sample
  localparam int SelW          = 3;   // read_channel width
  localparam int WidthW        = 16;  // stored pulse width
  localparam int TimeW         = 32;  // timestamps and periods
  localparam int CountW        = 3;   // ready_count width
  localparam int CfgIdxW       = 2;
  localparam int OutDepth      = 3;   // output buffer entries
  localparam int InDataW       = 72;
  localparam int OutDataW      = 56;

  localparam logic [CfgIdxW-1:0] CfgWidthMin  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidthMax  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriodMin = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPeriodMax = 2'd3;

  localparam logic [WidthW-1:0] WidthMinRst  = 16'd800;
  localparam logic [WidthW-1:0] WidthMaxRst  = 16'd2200;
  localparam logic [TimeW-1:0]  PeriodMinRst = 32'd14000;
  localparam logic [TimeW-1:0]  PeriodMaxRst = 32'd30000;

  typedef struct packed {
    logic [WidthW-1:0] width_min;
    logic [WidthW-1:0] width_max;
    logic [TimeW-1:0]  period_min;
    logic [TimeW-1:0]  period_max;
  } rpc_cfg_t;

  typedef struct packed {
    logic              ready;
    logic [WidthW-1:0] width;
  } rpc_lane_stat_t;

  typedef struct packed {
    logic [TimeW-1:0]  last_valid_ms;
    logic [CountW-1:0] ready_count;
    logic              all_ready;
    logic [WidthW-1:0] read_width_us;
  } rpc_res_t;

endpackage

### rtl/core/rpc_lane.sv
// One capture lane: edge detect, width and period checks, per-channel state.
// Depends on rpc_pkg.
module rpc_lane
  import rpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             pin,
  input  logic [TimeW-1:0] now_us,
  input  rpc_cfg_t         cfg,
  output logic             acc,
  output rpc_lane_stat_t   stat
);

  logic              prev_r, prev_nxt;
  logic [TimeW-1:0]  rise_r, rise_nxt;
  logic [TimeW-1:0]  conf_r, conf_nxt;
  logic [WidthW-1:0] width_r, width_nxt;
  logic              ready_r, ready_nxt;

  logic [TimeW-1:0] pw;
  logic [TimeW-1:0] per;
  logic             per_ok;
  logic             w_ok;
  logic             changed;

  assign pw      = now_us - rise_r;
  assign per     = rise_r - conf_r;
  assign per_ok  = (conf_r == '0) || (per >= cfg.period_min && per <= cfg.period_max);
  assign w_ok    = (pw >= {{(TimeW-WidthW){1'b0}}, cfg.width_min}) &&
                   (pw <= {{(TimeW-WidthW){1'b0}}, cfg.width_max});
  assign changed = pin ^ prev_r;
  assign acc     = en && changed && !pin && w_ok && per_ok;

  always_comb begin
    prev_nxt  = prev_r;
    rise_nxt  = rise_r;
    conf_nxt  = conf_r;
    width_nxt = width_r;
    ready_nxt = ready_r;
    if (en) begin
      prev_nxt = pin;
      if (changed && pin) begin
        rise_nxt = now_us;
      end
    end
    if (acc) begin
      width_nxt = pw[WidthW-1:0];
      ready_nxt = 1'b1;
      conf_nxt  = rise_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b1;
      rise_r  <= '0;
      conf_r  <= '0;
      width_r <= '0;
      ready_r <= 1'b0;
    end else begin
      prev_r  <= prev_nxt;
      rise_r  <= rise_nxt;
      conf_r  <= conf_nxt;
      width_r <= width_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign stat.ready = ready_r;
  assign stat.width = width_r;

  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |=> ready_r) else $error("ready bit cleared outside reset");

endmodule

### rtl/core/rpc_merge.sv
// Merge stage: read-back select, ready count and all-ready over the lanes.
// Depends on rpc_pkg.
module rpc_merge
  import rpc_pkg::*;
#(
  parameter int CHANNELS = RpcChannels
) (
  input  rpc_lane_stat_t   stat [CHANNELS],
  input  logic [SelW-1:0]  sel,
  input  logic [TimeW-1:0] last_ms,
  output rpc_res_t         res
);

  logic [CountW:0]   cnt;
  logic [WidthW-1:0] rd;
  logic              all_rdy;

  always_comb begin
    cnt     = '0;
    rd      = '0;
    all_rdy = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      cnt     = cnt + {{CountW{1'b0}}, stat[i].ready};
      all_rdy = all_rdy & stat[i].ready;
      if (sel == SelW'(i)) begin
        rd = stat[i].width;
      end
    end
  end

  // a count of eight wraps to zero in the three-bit field
  assign res.read_width_us = rd;
  assign res.all_ready     = all_rdy;
  assign res.ready_count   = cnt[CountW-1:0];
  assign res.last_valid_ms = last_ms;

endmodule

### rtl/core/rpc_out_buf.sv
// Small output buffer holding finished results until the sink takes them.
// Depends on rpc_pkg.
module rpc_out_buf
  import rpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rpc_res_t   push_data,
  input  logic       pop,
  output logic       not_empty,
  output rpc_res_t   head,
  output logic [1:0] level
);

  rpc_res_t   mem [OutDepth];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_r];
  assign level     = cnt_r;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == 2'(OutDepth-1)) ? 2'd0 : wr_r + 2'd1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == 2'(OutDepth-1)) ? 2'd0 : rd_r + 2'd1;
    end
    unique case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'(OutDepth) || do_pop)) else $error("push into full buffer");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(OutDepth)) else $error("buffer level out of range");

endmodule

### rtl/core/rc_pwm_pulse_capture.sv
// Top level of the RC PWM pulse capture block: config registers, lanes,
// merge stage and output buffer. Depends on rpc_pkg, rpc_lane, rpc_merge, rpc_out_buf.
//
//  Channel   Dir  Handshake              Payload
//  in_       in   in_tvalid/in_tready    in_tdata  (pin sample, timestamps, read select)
//  out_      out  out_tvalid/out_tready  out_tdata (width, ready flags, last ms)
//  cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One sample is accepted per cycle while in_tready is high; its result goes through
// the lane registers and the output buffer to out_. Every lane updates its channel
// state in the accept cycle; the merge stage reads it in the following cycle and
// writes a three-entry output buffer. in_tready drops only when that buffer plus
// the result in flight fill it. Reset (rst_n low, synchronous) loads the register
// defaults, idles pins high and clears all channel state; cfg_ready is always high.
module rc_pwm_pulse_capture
  import rpc_pkg::*;
#(
  parameter int CHANNELS = RpcChannels
) (
  input  logic                clk,
  input  logic                rst_n,
  // [4:0] pin_levels, [36:5] now_us, [68:37] now_ms, [71:69] read_channel
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [15:0] read_width_us, [16] all_ready, [19:17] ready_count,
  // [51:20] last_valid_ms, [55:52] zero
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [TimeW-1:0]    cfg_data
);

  // Unpack the sample
  logic [PinW-1:0]  pins;
  logic [TimeW-1:0] now_us;
  logic [TimeW-1:0] now_ms;
  logic [SelW-1:0]  rd_sel;

  assign pins   = in_tdata[4:0];
  assign now_us = in_tdata[36:5];
  assign now_ms = in_tdata[68:37];
  assign rd_sel = in_tdata[71:69];

  // Configuration registers
  rpc_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CfgWidthMin:  cfg_nxt.width_min  = cfg_data[WidthW-1:0];
        CfgWidthMax:  cfg_nxt.width_max  = cfg_data[WidthW-1:0];
        CfgPeriodMin: cfg_nxt.period_min = cfg_data;
        CfgPeriodMax: cfg_nxt.period_max = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_min  <= WidthMinRst;
      cfg_r.width_max  <= WidthMaxRst;
      cfg_r.period_min <= PeriodMinRst;
      cfg_r.period_max <= PeriodMaxRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Flow control: hold input while buffer plus in-flight result reach its depth
  logic       in_acc;
  logic       pend_r;
  logic [1:0] buf_level;
  logic [2:0] occupancy;

  assign occupancy = {1'b0, buf_level} + {2'b00, pend_r};
  assign in_tready = (occupancy < 3'(OutDepth));
  assign in_acc    = in_tvalid && in_tready;

  // Lanes, one per channel; channels beyond the sampled pins read low
  logic           lane_acc  [CHANNELS];
  rpc_lane_stat_t lane_stat [CHANNELS];
  logic [CHANNELS-1:0] acc_vec;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    logic pin_g;
    if (g < PinW) begin : g_pin
      assign pin_g = pins[g];
    end else begin : g_nopin
      assign pin_g = 1'b0;
    end

    rpc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (in_acc),
      .pin    (pin_g),
      .now_us (now_us),
      .cfg    (cfg_r),
      .acc    (lane_acc[g]),
      .stat   (lane_stat[g])
    );

    assign acc_vec[g] = lane_acc[g];
  end

  // Item-wide state: last accept time, read select, result in flight
  logic [TimeW-1:0] last_ms_r, last_ms_nxt;
  logic [SelW-1:0]  sel_r, sel_nxt;
  logic             pend_nxt;

  always_comb begin
    last_ms_nxt = (|acc_vec) ? now_ms : last_ms_r;
    sel_nxt     = in_acc ? rd_sel : sel_r;
    pend_nxt    = in_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ms_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      last_ms_r <= last_ms_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

  // Merge the lanes for the item accepted last cycle
  rpc_res_t res;

  rpc_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .stat    (lane_stat),
    .sel     (sel_r),
    .last_ms (last_ms_r),
    .res     (res)
  );

  // Output buffer
  rpc_res_t head;

  rpc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pend_r),
    .push_data (res),
    .pop       (out_tready),
    .not_empty (out_tvalid),
    .head      (head),
    .level     (buf_level)
  );

  assign out_tdata = {4'b0000, head.last_valid_ms, head.ready_count,
                      head.all_ready, head.read_width_us};

  a_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pend_r) else $error("accepted item lost before merge");

  a_valid_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_tvalid) else $error("merged result not presented");

  a_accept_only_on_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (|acc_vec) |-> in_acc) else $error("lane accepted pulse without input item");

endmodule
